// ===== sv/scpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scpq_pkg;

  // parameter defaults
  localparam int DEPTH_DEF        = 16;
  localparam int PRIO_BITS_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  // fixed field widths
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 2;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register byte addresses
  localparam logic [CFG_AW-1:0] ADDR_CAPACITY = CFG_AW'(0);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== sv/scpq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface scpq_in_if #(
  parameter int PRIO_BITS    = scpq_pkg::PRIO_BITS_DEF,
  parameter int PAYLOAD_BITS = scpq_pkg::PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [PRIO_BITS-1:0]    prio_in;
  logic [PAYLOAD_BITS-1:0] payload_in;

  modport source (output valid, output op, output prio_in, output payload_in, input ready);
  modport sink   (input valid, input op, input prio_in, input payload_in, output ready);
endinterface
`default_nettype wire

// ===== sv/scpq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface scpq_out_if #(
  parameter int PRIO_BITS    = scpq_pkg::PRIO_BITS_DEF,
  parameter int PAYLOAD_BITS = scpq_pkg::PAYLOAD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [scpq_pkg::STAT_W-1:0] status;
  logic [PRIO_BITS-1:0]        prio_out;
  logic [PAYLOAD_BITS-1:0]     payload_out;
  logic [scpq_pkg::CNT_W-1:0]  count;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, output status, output prio_out, output payload_out,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input prio_out, input payload_out,
                  input count, input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

// ===== sv/scpq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module scpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = scpq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/sorted_circular_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// steps, accept to result valid: a rejected beat or an enqueue into an empty queue goes
// straight to the finish step; a dequeue reads the head entry (registered ram read) first;
// any other enqueue walks past k entries, one compare and move per cycle, k <= capacity - 1
// flow: one beat at a time, next accept the cycle after the result loads; a stalled
// result holds the block in its last step
// reset (synchronous, rst_n low): queue empty, head at slot 0, capacity 16; ram not cleared
module sorted_circular_priority_queue_core #(
  parameter int DEPTH        = scpq_pkg::DEPTH_DEF,
  parameter int PRIO_BITS    = scpq_pkg::PRIO_BITS_DEF,
  parameter int PAYLOAD_BITS = scpq_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  scpq_in_if.sink                            in_ch,
  scpq_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scpq_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [scpq_pkg::CFG_DW-1:0]   pwdata,
  output      logic [scpq_pkg::CFG_DW-1:0]   prdata,
  output      logic                          pready
);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = scpq_pkg::CNT_W;
  localparam int CAP_W   = scpq_pkg::CAP_W;
  localparam int ENT_W   = PRIO_BITS + PAYLOAD_BITS;
  localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  // largest slot count the 5-bit register can reach within this depth
  localparam int CAP_MAX = (DEPTH > (2**CAP_W - 1)) ? (2**CAP_W - 1) : DEPTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PLACE,
    S_DEQ,
    S_FIN
  } state_t;

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_t                      state_r, state_nxt;
  logic [CAP_W-1:0]            cap_r, cap_nxt;
  logic [IDX_W-1:0]            head_r, head_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  // slot the new entry currently sits in, and the slot in front being read
  logic [IDX_W-1:0]            cur_r, cur_nxt;
  logic [IDX_W-1:0]            prv_r, prv_nxt;
  logic [PRIO_BITS-1:0]        new_prio_r, new_prio_nxt;
  logic [PAYLOAD_BITS-1:0]     new_pay_r, new_pay_nxt;
  scpq_pkg::status_t           res_status_r, res_status_nxt;
  logic [PRIO_BITS-1:0]        res_prio_r, res_prio_nxt;
  logic [PAYLOAD_BITS-1:0]     res_pay_r, res_pay_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  scpq_pkg::status_t           out_status_r, out_status_nxt;
  logic [PRIO_BITS-1:0]        out_prio_r, out_prio_nxt;
  logic [PAYLOAD_BITS-1:0]     out_pay_r, out_pay_nxt;
  logic [CNT_W-1:0]            out_count_r, out_count_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic                        out_full_r, out_full_nxt;

  // ram port
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [ENT_W-1:0]            ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [ENT_W-1:0]            ram_rdata;
  logic [PRIO_BITS-1:0]        rd_prio;
  logic [PAYLOAD_BITS-1:0]     rd_pay;

  // derived queue geometry
  logic [CNT_W-1:0]            cap_eff;
  logic [SUM_W-1:0]            tail_sum;
  logic [IDX_W-1:0]            tail_idx;
  logic [IDX_W-1:0]            tail_prev;
  logic [IDX_W-1:0]            prv_prev;
  logic [IDX_W-1:0]            head_inc;
  logic                        in_acc;
  logic                        out_acc;
  logic                        cfg_wr;

  scpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_prio = ram_rdata[ENT_W-1 -: PRIO_BITS];
  assign rd_pay  = ram_rdata[PAYLOAD_BITS-1:0];

  // slot index one step toward the head, wrapping at the effective capacity
  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
    logic [IDX_W-1:0] last;
    last = IDX_W'(cap - CNT_W'(1));
    return (idx == '0) ? last : idx - IDX_W'(1);
  endfunction

  // zero reads as one, anything past the depth reads as the depth
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_r > CAP_W'(CAP_MAX)) begin
      cap_eff = CNT_W'(CAP_MAX);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // tail = (head + count) mod cap; head is below cap and count at most cap, so one subtract
  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(cap_eff)) begin
      tail_sum = tail_sum - SUM_W'(cap_eff);
    end
    tail_idx = IDX_W'(tail_sum);
  end

  assign tail_prev = step_back(tail_idx, cap_eff);
  assign prv_prev  = step_back(prv_r, cap_eff);
  assign head_inc  = (SUM_W'(head_r) + SUM_W'(1) == SUM_W'(cap_eff)) ? '0
                                                                      : head_r + IDX_W'(1);

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.prio_out    = out_prio_r;
  assign out_ch.payload_out = out_pay_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;

  // config port: zero-wait apb; the user must write only while idle, the block does not enforce it
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == scpq_pkg::ADDR_CAPACITY) ? scpq_pkg::CFG_DW'(cap_r) : '0;

  // ---------------------------------------------------------------------------
  // sequencer: the one prio comparator and the ram port are reused every step
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prv_nxt        = prv_r;
    new_prio_nxt   = new_prio_r;
    new_pay_nxt    = new_pay_r;
    res_status_nxt = res_status_r;
    res_prio_nxt   = res_prio_r;
    res_pay_nxt    = res_pay_r;

    out_valid_nxt  = out_valid_r && !out_acc;
    out_status_nxt = out_status_r;
    out_prio_nxt   = out_prio_r;
    out_pay_nxt    = out_pay_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;

    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = {new_prio_r, new_pay_r};
    ram_raddr = prv_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_prio_nxt = in_ch.prio_in;
          new_pay_nxt  = in_ch.payload_in;
          res_prio_nxt = '0;
          res_pay_nxt  = '0;
          if (in_ch.op == scpq_pkg::OP_DEQ) begin
            if (count_r == '0) begin
              res_status_nxt = scpq_pkg::STAT_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              // head entry comes back from the ram next cycle
              ram_raddr      = head_r;
              res_status_nxt = scpq_pkg::STAT_DEQ;
              state_nxt      = S_DEQ;
            end
          end else if (count_r == cap_eff) begin
            res_status_nxt = scpq_pkg::STAT_FULL;
            state_nxt      = S_FIN;
          end else begin
            res_status_nxt = scpq_pkg::STAT_ENQ;
            cur_nxt        = tail_idx;
            if (count_r == '0) begin
              // nothing to pass, lands at the tail right away
              ram_we    = 1'b1;
              ram_waddr = tail_idx;
              ram_wdata = {in_ch.prio_in, in_ch.payload_in};
              state_nxt = S_FIN;
            end else begin
              ram_raddr = tail_prev;
              prv_nxt   = tail_prev;
              state_nxt = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        // strictly greater moves ahead, equal keeps arrival order
        if (new_prio_r > rd_prio) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = ram_rdata;
          cur_nxt   = prv_r;
          if (prv_r == head_r) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr = prv_prev;
            prv_nxt   = prv_prev;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          state_nxt = S_FIN;
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        state_nxt = S_FIN;
      end

      S_DEQ: begin
        res_prio_nxt = rd_prio;
        res_pay_nxt  = rd_pay;
        state_nxt    = S_FIN;
      end

      S_FIN: begin
        // wait for the output register to free up, then commit head and count
        if (!out_valid_r || out_acc) begin
          case (res_status_r)
            scpq_pkg::STAT_ENQ: begin
              count_nxt = count_r + CNT_W'(1);
            end
            scpq_pkg::STAT_DEQ: begin
              count_nxt = count_r - CNT_W'(1);
              head_nxt  = (count_r == CNT_W'(1)) ? '0 : head_inc;
            end
            default: begin
            end
          endcase
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_prio_nxt   = res_prio_r;
          out_pay_nxt    = res_pay_r;
          out_count_nxt  = count_nxt;
          out_empty_nxt  = (count_nxt == '0);
          out_full_nxt   = (count_nxt == cap_eff);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // capacity write empties the queue since the slot mapping changes
    if (cfg_wr && paddr == scpq_pkg::ADDR_CAPACITY) begin
      cap_nxt   = pwdata[CAP_W-1:0];
      head_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= scpq_pkg::CAP_RESET;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    prv_r        <= prv_nxt;
    new_prio_r   <= new_prio_nxt;
    new_pay_r    <= new_pay_nxt;
    res_status_r <= res_status_nxt;
    res_prio_r   <= res_prio_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_prio_r   <= out_prio_nxt;
    out_pay_r    <= out_pay_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end
endmodule
`default_nettype wire
